FILE: hdl/u8n_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8n_pkg
// Shared types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8
// transcoder with newline normalization.
// ----------------------------------------------------------------------------
package u8n_pkg;

  // Special code units and code points
  localparam logic [15:0] UNIT_CR     = 16'h000d;
  localparam logic [15:0] UNIT_LF     = 16'h000a;
  localparam logic [15:0] HI_FIRST    = 16'hd800;
  localparam logic [15:0] HI_LAST     = 16'hdbff;
  localparam logic [15:0] LO_FIRST    = 16'hdc00;
  localparam logic [15:0] LO_LAST     = 16'hdfff;
  localparam logic [20:0] CP_LF       = 21'h00000a;
  localparam logic [20:0] CP_REPLACE  = 21'h00fffd;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

  // Command queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Input and output words
  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       final_byte;
  } out_item_t;

  // One queued command: one or two code points settled by one input word
  typedef struct packed {
    logic [20:0] cp0;
    logic        cp1_valid;
    logic [20:0] cp1;
    logic        ending;
  } cmd_t;

  function automatic logic is_high(input logic [15:0] u);
    return (u >= HI_FIRST) && (u <= HI_LAST);
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return (u >= LO_FIRST) && (u <= LO_LAST);
  endfunction

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] byte_count(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h000080) begin
      n = 3'd1;
    end else if (cp < 21'h000800) begin
      n = 3'd2;
    end else if (cp < 21'h010000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Byte at position idx (0 = lead byte) of the encoding of cp
  function automatic logic [7:0] utf8_at(input logic [20:0] cp, input logic [1:0] idx);
    logic [2:0] n;
    logic [2:0] rem;
    logic [7:0] b;
    n   = byte_count(cp);
    rem = n - 3'd1 - {1'b0, idx};
    b   = 8'h00;
    if (idx == 2'd0) begin
      case (n)
        3'd1:    b = cp[7:0];
        3'd2:    b = 8'hc0 | {3'b000, cp[10:6]};
        3'd3:    b = 8'he0 | {4'h0, cp[15:12]};
        default: b = 8'hf0 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      case (rem)
        3'd0:    b = 8'h80 | {2'b00, cp[5:0]};
        3'd1:    b = 8'h80 | {2'b00, cp[11:6]};
        default: b = 8'h80 | {2'b00, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

FILE: hdl/utf16_to_utf8_newline_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_newline_normalizer
// UTF-16 to UTF-8 transcoder that folds CR and CRLF into LF and replaces lone
// surrogates with U+FFFD.
// ----------------------------------------------------------------------------
// The input takes one UTF-16 word per cycle while the four-entry command
// queue has room; the output gives one UTF-8 byte per cycle while the output
// register is empty or out_ready is high. A word settles zero bytes when it
// is held or folded away, one to four normally, up to six when a held unit is
// flushed together with it. The byte encoder sets the sustained rate. A word's
// first byte passes through the command queue and then the registered output
// stage. A set end_of_text or a zero word flushes any pending CR or high
// surrogate and marks the last byte with final_byte; a zero word with nothing
// pending produces no byte.
// ----------------------------------------------------------------------------
module utf16_to_utf8_newline_normalizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8n_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output u8n_pkg::out_item_t out_item
);
  import u8n_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  u8n_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  u8n_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  u8n_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: hdl/u8n_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8n_front
// Accepts UTF-16 words, tracks the pending CR or high surrogate, and turns
// each word into a command of up to two code points for the back end.
// ----------------------------------------------------------------------------
module u8n_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  u8n_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             push,
  output u8n_pkg::cmd_t    push_cmd
);
  import u8n_pkg::*;

  logic        held_valid;
  logic [15:0] held_unit;
  logic        held_valid_next;
  logic [15:0] held_unit_next;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the word against the held unit
  always_comb begin
    logic [15:0] u;
    logic        ending;
    logic        consumed;
    logic        a_valid;
    logic [20:0] a_cp;
    logic        b_valid;
    logic [20:0] b_cp;
    u        = in_item.code_unit;
    ending   = in_item.end_of_text || (u == 16'h0000);
    consumed = 1'b0;
    a_valid  = 1'b0;
    a_cp     = CP_LF;
    b_valid  = 1'b0;
    b_cp     = CP_LF;
    held_valid_next = 1'b0;
    held_unit_next  = 16'h0000;

    // Settle the held unit
    if (held_valid) begin
      a_valid = 1'b1;
      if (held_unit == UNIT_CR) begin
        a_cp     = CP_LF;
        consumed = (u == UNIT_LF);
      end else if (is_low(u)) begin
        a_cp     = CP_SUPP_BASE + {1'b0, held_unit[9:0], u[9:0]};
        consumed = 1'b1;
      end else begin
        a_cp = CP_REPLACE;
      end
    end

    // Handle the new word
    if (!consumed && (u != 16'h0000)) begin
      if ((u == UNIT_CR) || is_high(u)) begin
        if (ending) begin
          b_valid = 1'b1;
          b_cp    = (u == UNIT_CR) ? CP_LF : CP_REPLACE;
        end else begin
          held_valid_next = 1'b1;
          held_unit_next  = u;
        end
      end else if (is_low(u)) begin
        b_valid = 1'b1;
        b_cp    = CP_REPLACE;
      end else begin
        b_valid = 1'b1;
        b_cp    = {5'b00000, u};
      end
    end

    // Pack the first emitted code point into slot 0
    push_cmd.ending    = ending;
    push_cmd.cp0       = a_valid ? a_cp : b_cp;
    push_cmd.cp1_valid = a_valid && b_valid;
    push_cmd.cp1       = b_cp;
    push               = accept && (a_valid || b_valid);
  end

  // Hold the pending unit
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_unit  <= 16'h0000;
    end else if (accept) begin
      held_valid <= held_valid_next;
      held_unit  <= held_unit_next;
    end
  end

endmodule

FILE: hdl/u8n_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8n_queue
// Short command queue between the front end and the byte encoder.
// ----------------------------------------------------------------------------
module u8n_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u8n_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output u8n_pkg::cmd_t head
);
  import u8n_pkg::*;

  cmd_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;

  assign full  = (count == Q_CW'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from empty queue");
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue occupancy out of range");
  a_count_grow : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue occupancy did not grow on push");

endmodule

FILE: hdl/u8n_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8n_back
// Expands queued code points into UTF-8 bytes, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module u8n_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  u8n_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u8n_pkg::out_item_t out_item
);
  import u8n_pkg::*;

  logic        sel;
  logic [1:0]  idx;
  logic [20:0] cur_cp;
  logic [2:0]  cur_cnt;
  logic        last_of_cp;
  logic        last_of_cmd;
  logic        load;

  // Select the current code point and byte position
  assign cur_cp      = sel ? head.cp1 : head.cp0;
  assign cur_cnt     = byte_count(cur_cp);
  assign last_of_cp  = ({1'b0, idx} == (cur_cnt - 3'd1));
  assign last_of_cmd = last_of_cp && (sel || !head.cp1_valid);
  assign load        = !q_empty && (!out_valid || out_ready);
  assign pop         = load && last_of_cmd;

  // Advance through the command and hold the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (last_of_cmd) begin
          sel <= 1'b0;
          idx <= 2'd0;
        end else if (last_of_cp) begin
          sel <= 1'b1;
          idx <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.utf8_byte  <= utf8_at(cur_cp, idx);
      out_item.final_byte <= last_of_cmd && head.ending;
    end
  end

endmodule
